@@ rtl/assert_macros.svh @@
// Assertion macros used by the timer bank controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define STB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition must never be true outside reset
`define STB_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ rtl/stb_pkg.sv @@
// Types and constants shared by the timer bank controller and datapath
package stb_pkg;

    localparam int TIMER_SLOTS = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int KIND_W      = 3;
    localparam int KEY_W       = 16;
    localparam int VAL_W       = 32;
    localparam int DATA_W      = 56;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SERVICE = 3'd4;

    // What the result register is loaded with
    typedef enum logic [1:0] {
        RES_OK,
        RES_ERR,
        RES_COUNT,
        RES_FIRED
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     idx_clr;
        logic     idx_inc;
        logic     tick_upd;
        logic     del_slot;
        logic     claim_slot;
        logic     svc_clr;
        logic     res_load;
        res_sel_t res_sel;
        logic     res_last;
    } stb_cmd_t;

    typedef struct packed {
        logic key_hit;
        logic slot_en;
        logic slot_pend;
        logic idx_last;
        logic pend_above;
        logic out_busy;
    } stb_sts_t;

endpackage

@@ rtl/stb_datapath.sv @@
// Slot register file, slot walk pointer, command capture and result register
module stb_datapath
    import stb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  stb_cmd_t          cmd,
    output stb_sts_t          sts,
    input  logic [DATA_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // status, count_value[32:1], fired_key[48:33]
    output logic              m_tuser,   // fired
    output logic              m_tlast
);

    logic [TIMER_SLOTS-1:0] en_reg;
    logic [TIMER_SLOTS-1:0] pend_reg;
    logic [TIMER_SLOTS-1:0] os_reg;
    logic [VAL_W-1:0]       period_reg [TIMER_SLOTS];
    logic [VAL_W-1:0]       count_reg  [TIMER_SLOTS];
    logic [KEY_W-1:0]       key_reg    [TIMER_SLOTS];

    logic [SLOT_W-1:0]      idx_reg;
    logic                   os_in_reg;
    logic [VAL_W-1:0]       period_in_reg;
    logic [KEY_W-1:0]       key_in_reg;

    logic                   m_tvalid_reg;
    logic [DATA_W-1:0]      m_tdata_reg;
    logic [DATA_W-1:0]      m_tdata_next;
    logic                   m_tuser_reg;
    logic                   m_tuser_next;
    logic                   m_tlast_reg;

    logic [TIMER_SLOTS-1:0] above_mask;
    logic [VAL_W-1:0]       cur_count;
    logic                   cur_due;

    assign cur_count = count_reg[idx_reg];
    assign cur_due   = (cur_count >= period_reg[idx_reg]);

    always_comb begin
        for (int j = 0; j < TIMER_SLOTS; j++) begin
            above_mask[j] = (SLOT_W'(j) > idx_reg);
        end
    end

    always_comb begin
        sts.key_hit    = (key_reg[idx_reg] == key_in_reg);
        sts.slot_en    = en_reg[idx_reg];
        sts.slot_pend  = pend_reg[idx_reg];
        sts.idx_last   = (idx_reg == SLOT_W'(TIMER_SLOTS - 1));
        sts.pend_above = |(pend_reg & above_mask);
        sts.out_busy   = m_tvalid_reg && !m_tready;
    end

    // Slot state: one slot touched per cycle, at the walk pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= '0;
            pend_reg <= '0;
            os_reg   <= '0;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                period_reg[i] <= '0;
                count_reg[i]  <= '0;
                key_reg[i]    <= '0;
            end
        end else begin
            if (cmd.tick_upd && en_reg[idx_reg]) begin
                if (cur_due) begin
                    if (os_reg[idx_reg]) begin
                        en_reg[idx_reg] <= 1'b0;
                    end
                    pend_reg[idx_reg]  <= 1'b1;
                    count_reg[idx_reg] <= '0;
                end else begin
                    count_reg[idx_reg] <= cur_count + VAL_W'(1);
                end
            end
            if (cmd.del_slot) begin
                en_reg[idx_reg]   <= 1'b0;
                pend_reg[idx_reg] <= 1'b0;
            end
            if (cmd.claim_slot) begin
                en_reg[idx_reg]     <= 1'b1;
                pend_reg[idx_reg]   <= 1'b0;
                os_reg[idx_reg]     <= os_in_reg;
                period_reg[idx_reg] <= period_in_reg;
                key_reg[idx_reg]    <= key_in_reg;
                count_reg[idx_reg]  <= '0;
            end
            if (cmd.svc_clr) begin
                pend_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + SLOT_W'(1);
        end
    end

    // Capture the operands of the accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            os_in_reg     <= s_tdata[0];
            period_in_reg <= s_tdata[32:1];
            key_in_reg    <= s_tdata[48:33];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        m_tdata_next = '0;
        m_tuser_next = 1'b0;
        unique case (cmd.res_sel)
            RES_OK: begin
            end
            RES_ERR: begin
                m_tdata_next[0] = 1'b1;
            end
            RES_COUNT: begin
                m_tdata_next[32:1] = cur_count;
            end
            RES_FIRED: begin
                m_tuser_next        = 1'b1;
                m_tdata_next[48:33] = key_reg[idx_reg];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
            m_tlast_reg <= cmd.res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ rtl/stb_ctrl.sv @@
// Command sequencer: walks the slot bank one slot per cycle, stalled by out_busy
`include "assert_macros.svh"

module stb_ctrl
    import stb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KIND_W-1:0] s_tuser,   // kind
    input  stb_sts_t          sts,
    output stb_cmd_t          cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TICK = 3'd1;
    localparam logic [2:0] ST_DEL  = 3'd2;
    localparam logic [2:0] ST_FREE = 3'd3;
    localparam logic [2:0] ST_GET  = 3'd4;
    localparam logic [2:0] ST_SVC  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic             create_reg, create_next;
    logic [CNT_W-1:0] svc_cnt_reg, svc_cnt_next;
    logic             svc_last;
    logic             s_acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign svc_last = !sts.pend_above || (svc_cnt_reg == CNT_W'(MAX_RESULTS - 1));

    always_comb begin
        cmd          = '0;
        cmd.res_sel  = RES_OK;
        state_next   = state_reg;
        create_next  = create_reg;
        svc_cnt_next = svc_cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load     = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    svc_cnt_next = '0;
                    create_next  = (s_tuser == KIND_CREATE);
                    unique case (s_tuser)
                        KIND_TICK:    state_next = ST_TICK;
                        KIND_CREATE:  state_next = ST_DEL;
                        KIND_DELETE:  state_next = ST_DEL;
                        KIND_GET:     state_next = ST_GET;
                        KIND_SERVICE: state_next = ST_SVC;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                cmd.tick_upd = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DEL: begin
                if (sts.key_hit) begin
                    if (create_reg) begin
                        cmd.del_slot = 1'b1;
                        cmd.idx_clr  = 1'b1;
                        state_next   = ST_FREE;
                    end else if (!sts.out_busy) begin
                        cmd.del_slot = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (sts.idx_last) begin
                    if (create_reg) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_FREE;
                    end else if (!sts.out_busy) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ERR;
                        cmd.res_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_FREE: begin
                if (!sts.slot_en && !sts.slot_pend) begin
                    if (!sts.out_busy) begin
                        cmd.claim_slot = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_last   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (sts.idx_last) begin
                    if (!sts.out_busy) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ERR;
                        cmd.res_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_GET: begin
                if (sts.key_hit && sts.slot_en) begin
                    if (!sts.out_busy) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_COUNT;
                        cmd.res_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (sts.idx_last) begin
                    if (!sts.out_busy) begin
                        cmd.res_load = 1'b1;
                        cmd.res_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_SVC: begin
                if (sts.slot_pend) begin
                    if (!sts.out_busy) begin
                        cmd.svc_clr  = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_FIRED;
                        cmd.res_last = svc_last;
                        svc_cnt_next = svc_cnt_reg + CNT_W'(1);
                        if (svc_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                end else if (sts.idx_last) begin
                    // nothing was pending: report one empty result
                    if (!sts.out_busy) begin
                        cmd.res_load = 1'b1;
                        cmd.res_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            create_reg  <= 1'b0;
            svc_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            create_reg  <= create_next;
            svc_cnt_reg <= svc_cnt_next;
        end
    end

    `STB_NEVER(a_res_when_busy, cmd.res_load && sts.out_busy, "result loaded over a waiting result")
    `STB_ASSERT(a_tick_walk, (s_acc && s_tuser == KIND_TICK) |=> (state_reg == ST_TICK), "tick did not start a walk")
    `STB_NEVER(a_svc_overrun, svc_cnt_reg > CNT_W'(MAX_RESULTS), "service reported too many slots")
    `STB_NEVER(a_slot_write_idle, (state_reg == ST_IDLE) && (cmd.tick_upd || cmd.del_slot || cmd.claim_slot || cmd.svc_clr), "slot written while idle")

endmodule

@@ rtl/soft_timer_bank.sv @@
// Top level of the timer bank: controller and slot datapath
//
// A bank of TIMER_SLOTS timer slots driven by a command stream. Each tick,
// create, delete, get or service transaction is taken with s_tready high and
// then walked over the slot register file one slot per cycle: a tick visits
// every slot, delete and get search for the key, create searches for the key
// and then for a free slot, and service walks until the last pending slot.
// Any cycle in which a new result would have to wait behind an unaccepted one
// stalls the walk. A finished result sits in the output register while the
// next transaction is taken. Service returns one transaction per pending slot
// (m_tuser high), or a single empty one when nothing is pending; m_tlast marks
// the final one.
module soft_timer_bank
    import stb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // one_shot, period[32:1], owner_key[48:33]
    input  logic [KIND_W-1:0] s_tuser,   // kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // status, count_value[32:1], fired_key[48:33]
    output logic              m_tuser,   // fired
    output logic              m_tlast
);

    stb_cmd_t cmd;
    stb_sts_t sts;

    stb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    stb_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/sv/soft_timer_bank_test.sv @@
// Testbench for the timer bank: directed and random command streams checked against a slot model
module soft_timer_bank_test;
    import stb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES   = 4 * TIMER_SLOTS + 16;
    localparam int MAX_GAP        = 12;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] count_value;
        logic             fired;
        logic [KEY_W-1:0] fired_key;
        logic             last;
    } timer_result_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;   // one_shot, period[32:1], owner_key[48:33]
    logic [KIND_W-1:0] s_tuser  = '0;   // kind
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // status, count_value[32:1], fired_key[48:33]
    logic              m_tuser;         // fired
    logic              m_tlast;

    // Shadow copy of the slot bank
    logic             bank_en     [TIMER_SLOTS];
    logic             bank_pend   [TIMER_SLOTS];
    logic             bank_once   [TIMER_SLOTS];
    logic [VAL_W-1:0] bank_period [TIMER_SLOTS];
    logic [VAL_W-1:0] bank_count  [TIMER_SLOTS];
    logic [KEY_W-1:0] bank_key    [TIMER_SLOTS];

    timer_result_t due_results[$];

    int  mismatches   = 0;
    int  cycle_count  = 0;
    bit  idle_on      = 1'b1;
    int  rx_hold_reqs = 0;
    int  rx_hold_seen = 0;
    int  rx_hold_left = 0;
    int  rx_wait      = 0;

    soft_timer_bank dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, due_results.size());
            $display("** soft_timer_bank: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic void push_result(logic status, logic [VAL_W-1:0] cnt, logic fired,
                                        logic [KEY_W-1:0] key, logic last);
        timer_result_t r;
        r.status      = status;
        r.count_value = cnt;
        r.fired       = fired;
        r.fired_key   = key;
        r.last        = last;
        due_results.push_back(r);
    endfunction

    function automatic void clear_bank();
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            bank_en[i]     = 1'b0;
            bank_pend[i]   = 1'b0;
            bank_once[i]   = 1'b0;
            bank_period[i] = '0;
            bank_count[i]  = '0;
            bank_key[i]    = '0;
        end
    endfunction

    // Drop the lowest slot holding the key, enabled or not
    function automatic bit drop_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (bank_key[i] == key) begin
                bank_en[i]   = 1'b0;
                bank_pend[i] = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Update the shadow bank for one command and queue the results it causes
    function automatic void apply_command(logic [KIND_W-1:0] kind, logic once,
                                          logic [VAL_W-1:0] per, logic [KEY_W-1:0] key);
        logic             err;
        logic [VAL_W-1:0] cnt;
        int               n;
        case (kind)
            KIND_TICK: begin
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (bank_en[i]) begin
                        if (bank_count[i] >= bank_period[i]) begin
                            if (bank_once[i])
                                bank_en[i] = 1'b0;
                            bank_pend[i]  = 1'b1;
                            bank_count[i] = '0;
                        end else begin
                            bank_count[i] = bank_count[i] + VAL_W'(1);
                        end
                    end
                end
            end
            KIND_CREATE: begin
                err = 1'b1;
                void'(drop_key(key));
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (err && !bank_en[i] && !bank_pend[i]) begin
                        bank_en[i]     = 1'b1;
                        bank_once[i]   = once;
                        bank_period[i] = per;
                        bank_key[i]    = key;
                        bank_count[i]  = '0;
                        err = 1'b0;
                    end
                end
                push_result(err, '0, 1'b0, '0, 1'b1);
            end
            KIND_DELETE: begin
                push_result(!drop_key(key), '0, 1'b0, '0, 1'b1);
            end
            KIND_GET: begin
                cnt = '0;
                for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
                    if (bank_key[i] == key && bank_en[i])
                        cnt = bank_count[i];
                end
                push_result(1'b0, cnt, 1'b0, '0, 1'b1);
            end
            KIND_SERVICE: begin
                n = 0;
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (bank_pend[i] && n < MAX_RESULTS) begin
                        bank_pend[i] = 1'b0;
                        push_result(1'b0, '0, 1'b1, bank_key[i], 1'b0);
                        n++;
                    end
                end
                if (n == 0)
                    push_result(1'b0, '0, 1'b0, '0, 1'b1);
                else
                    due_results[$].last = 1'b1;
            end
            default: begin
                // unused kinds are ignored by the block
            end
        endcase
    endfunction

    task automatic report_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        timer_result_t want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b tlast %0b",
                     $time, m_tdata, m_tuser, m_tlast);
            mismatches++;
        end else begin
            want = due_results.pop_front();
            report_field("status", VAL_W'(want.status), VAL_W'(m_tdata[0]));
            report_field("count_value", want.count_value, m_tdata[32:1]);
            report_field("fired", VAL_W'(want.fired), VAL_W'(m_tuser));
            report_field("fired_key", VAL_W'(want.fired_key), VAL_W'(m_tdata[48:33]));
            report_field("last", VAL_W'(want.last), VAL_W'(m_tlast));
        end
    endtask

    // Result side: check each transaction, then draw the next ready gap, or hold m_tready low after a hold request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (rx_hold_seen != rx_hold_reqs) begin
                rx_hold_seen <= rx_hold_reqs;
                rx_hold_left <= RX_HOLD_CYCLES;
                m_tready     <= 1'b0;
            end else if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= (rx_hold_left == 1);
            end else if (m_tvalid && m_tready) begin
                int w;
                w = draw_gap();
                rx_wait  <= w;
                m_tready <= (w == 0);
            end else if (rx_wait > 0) begin
                rx_wait  <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_command(logic [KIND_W-1:0] kind, logic once = 1'b0,
                                logic [VAL_W-1:0] per = '0, logic [KEY_W-1:0] key = '0);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - 1 - VAL_W - KEY_W){1'b0}}, key, per, once};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        apply_command(kind, once, per, key);
    endtask

    // Hold the input side until every due result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_reset_state();
        // cleared slots hold key zero, so delete matches one that was never created
        send_command(KIND_GET, 1'b0, '0, 16'h0000);
        send_command(KIND_DELETE, 1'b0, '0, 16'h0000);
        send_command(KIND_SERVICE);
        for (int k = KIND_SERVICE + 1; k < (1 << KIND_W); k++)
            send_command(k[KIND_W-1:0], 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    task automatic test_create_modes();
        send_command(KIND_CREATE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_command(KIND_CREATE, 1'b0, 32'd3, 16'd1);
        send_command(KIND_CREATE, 1'b1, 32'd1, 16'd2);
        // re-create replaces the earlier slot of the same key
        send_command(KIND_CREATE, 1'b0, 32'd0, 16'd1);
    endtask

    task automatic test_firing();
        repeat (3) send_command(KIND_TICK);
        send_command(KIND_GET, 1'b0, '0, 16'd1);
        send_command(KIND_GET, 1'b0, '0, 16'hFFFF);
        send_command(KIND_SERVICE);
    endtask

    task automatic test_bank_full();
        for (int k = 3; k <= 9; k++)
            send_command(KIND_CREATE, k[0], k, k[KEY_W-1:0]);
        send_command(KIND_DELETE, 1'b0, '0, 16'h1234);
    endtask

    task automatic test_output_stall();
        idle_on = 1'b0;
        repeat (2) send_command(KIND_TICK);
        rx_hold_reqs++;
        // keep offering while results back up behind the stalled receiver
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0)
                send_command(KIND_SERVICE);
            else if (i % 3 == 1)
                send_command(KIND_GET, 1'b0, '0, i[KEY_W-1:0]);
            else
                send_command(KIND_TICK);
        end
        idle_on = 1'b1;
        wait_results_drained();
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        return ($urandom_range(0, 4) != 0) ? KEY_W'($urandom_range(0, 11))
                                           : KEY_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [VAL_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 4);
        else if (r < 85)
            return $urandom_range(5, 20);
        return $urandom;
    endfunction

    task automatic test_random_traffic(int items);
        int               r;
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < items; i++) begin
            if (i % 25 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (i == items / 2)
                wait_results_drained();
            r = $urandom_range(0, 99);
            if (r < 40)
                kind = KIND_TICK;
            else if (r < 62)
                kind = KIND_CREATE;
            else if (r < 72)
                kind = KIND_DELETE;
            else if (r < 84)
                kind = KIND_GET;
            else if (r < 97)
                kind = KIND_SERVICE;
            else
                kind = KIND_SERVICE + KIND_W'($urandom_range(1, 3));
            send_command(kind, 1'($urandom_range(0, 1)), pick_period(), pick_key());
        end
    endtask

    initial begin
        clear_bank();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_create_modes();
        test_firing();
        test_bank_full();
        test_output_stall();
        test_random_traffic(112);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("** soft_timer_bank: PASSED **");
        else
            $display("** soft_timer_bank: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/stb_pkg.sv
rtl/stb_datapath.sv
rtl/stb_ctrl.sv
rtl/soft_timer_bank.sv
tb/sv/soft_timer_bank_test.sv
